FILE: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Field types, character and command codes, controller states, and the
// command and status groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Channel field types.
  typedef logic [1:0]  kind_t;
  typedef logic [7:0]  char_t;
  typedef logic [10:0] idx_t;
  typedef logic [10:0] pos_t;
  typedef logic [4:0]  row_out_t;
  typedef logic [6:0]  col_out_t;
  typedef logic [15:0] cell_t;
  typedef logic [3:0]  color_t;
  typedef logic [1:0]  reg_idx_t;

  // Transaction kinds. The fourth code is a no-op that only reports the cursor.
  localparam kind_t KIND_PUT   = 2'd0;
  localparam kind_t KIND_CLEAR = 2'd1;
  localparam kind_t KIND_READ  = 2'd2;

  // Control characters.
  localparam char_t CH_BS    = 8'd8;
  localparam char_t CH_TAB   = 8'd9;
  localparam char_t CH_NL    = 8'd10;
  localparam char_t CH_CR    = 8'd13;
  localparam char_t CH_SPACE = 8'h20;

  localparam int TAB_STOP = 8;

  // Cell value after reset: white on black space.
  localparam cell_t RESET_CELL = 16'h0720;

  localparam color_t FG_RESET = 4'd7;
  localparam color_t BG_RESET = 4'd0;

  // Configuration register indexes.
  localparam reg_idx_t REG_FG = 2'd0;
  localparam reg_idx_t REG_BG = 2'd1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RWAIT,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic capture_read;
    logic cnt_zero;
    logic scroll_step;
    logic fill_step;
    logic fill_reset;
    logic load_result;
  } ctl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  bottom_wrap;
    logic  in_range;
    logic  copy_done;
    logic  fill_done;
    logic  out_hold;
  } ctl_sts_t;

endpackage

FILE: rtl/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_if: channel interfaces of the text console writer
// Request, response and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface tcw_req_if;
  logic            valid;
  logic            ready;
  tcw_pkg::kind_t  kind;
  tcw_pkg::char_t  char_code;
  tcw_pkg::idx_t   cell_index;

  modport source (output valid, output kind, output char_code, output cell_index,
                  input ready);
  modport sink (input valid, input kind, input char_code, input cell_index,
                output ready);
endinterface

interface tcw_rsp_if;
  logic               valid;
  logic               ready;
  tcw_pkg::pos_t      cursor_pos;
  tcw_pkg::row_out_t  cursor_row;
  tcw_pkg::col_out_t  cursor_col;
  tcw_pkg::cell_t     read_data;

  modport source (output valid, output cursor_pos, output cursor_row,
                  output cursor_col, output read_data, input ready);
  modport sink (input valid, input cursor_pos, input cursor_row,
                input cursor_col, input read_data, output ready);
endinterface

interface tcw_cfg_if;
  logic               valid;
  logic               ready;
  tcw_pkg::reg_idx_t  index;
  tcw_pkg::color_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath: cursor, colour registers, screen store and result register
// Carries out the commands of the controller and reports status back.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                clk,
  input  logic                rst,
  input  tcw_pkg::ctl_cmd_t   cmd,
  output tcw_pkg::ctl_sts_t   sts,
  input  tcw_pkg::kind_t      req_kind,
  input  tcw_pkg::char_t      req_char_code,
  input  tcw_pkg::idx_t       req_cell_index,
  input  logic                cfg_we,
  input  tcw_pkg::reg_idx_t   cfg_index,
  input  tcw_pkg::color_t     cfg_data,
  input  logic                rsp_ready,
  output logic                rsp_valid,
  output tcw_pkg::pos_t       rsp_cursor_pos,
  output tcw_pkg::row_out_t   rsp_cursor_row,
  output tcw_pkg::col_out_t   rsp_cursor_col,
  output tcw_pkg::cell_t      rsp_read_data
);

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int AW        = $clog2(CELLS);
  localparam int RW        = $clog2(ROWS);
  localparam int RXW       = $clog2(ROWS + 1);
  localparam int CLW       = $clog2(COLUMNS);
  localparam int CXW       = $clog2(COLUMNS + tcw_pkg::TAB_STOP);
  localparam int COPY_LAST = CELLS - COLUMNS;

  // Colour registers.
  tcw_pkg::color_t fg;
  tcw_pkg::color_t bg;

  // Cursor.
  logic [RW-1:0]  row;
  logic [CLW-1:0] col;

  // Latched transaction.
  tcw_pkg::kind_t kind;
  tcw_pkg::char_t ch;
  tcw_pkg::idx_t  idx;

  // Sweep counter and the pending copy write of a scroll.
  logic [AW-1:0] cnt;
  logic          pend;
  logic [AW-1:0] pend_addr;

  tcw_pkg::cell_t rd;

  // RAM ports.
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  tcw_pkg::cell_t ram_wdata;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  tcw_pkg::cell_t ram_rdata;

  logic [CXW-1:0] col_x;
  logic [RXW-1:0] row_x;
  logic           col_wrap;
  logic           bottom_wrap;
  logic [CLW-1:0] col_next;
  logic [RW-1:0]  row_next;
  logic           printable;
  logic           in_range;
  logic           copy_active;
  logic [AW-1:0]  cur_addr;
  tcw_pkg::cell_t fill_cell;

  assign cur_addr  = AW'(AW'(row) * AW'(COLUMNS)) + AW'(col);
  assign in_range  = 32'(idx) < CELLS;
  assign printable = (ch != tcw_pkg::CH_BS) && (ch != tcw_pkg::CH_TAB) &&
                     (ch != tcw_pkg::CH_NL) && (ch != tcw_pkg::CH_CR);
  assign copy_active = cnt < AW'(COPY_LAST);
  assign fill_cell = cmd.fill_reset ? tcw_pkg::RESET_CELL
                                    : {bg, fg, tcw_pkg::CH_SPACE};

  // Cursor movement for a put-character transaction.
  always_comb begin
    case (ch)
      tcw_pkg::CH_NL: begin
        col_x = '0;
      end
      tcw_pkg::CH_CR: begin
        col_x = '0;
      end
      tcw_pkg::CH_TAB: begin
        col_x = (CXW'(col) + CXW'(tcw_pkg::TAB_STOP)) & ~CXW'(tcw_pkg::TAB_STOP - 1);
      end
      tcw_pkg::CH_BS: begin
        col_x = (col != '0) ? CXW'(col) - CXW'(1) : CXW'(col);
      end
      default: begin
        col_x = CXW'(col) + CXW'(1);
      end
    endcase
    col_wrap    = col_x >= CXW'(COLUMNS);
    row_x       = RXW'(row) + RXW'((ch == tcw_pkg::CH_NL) || col_wrap);
    bottom_wrap = row_x >= RXW'(ROWS);
    col_next    = col_wrap ? '0 : CLW'(col_x);
    row_next    = bottom_wrap ? RW'(ROWS - 1) : RW'(row_x);
  end

  // RAM port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt;
    ram_wdata = fill_cell;
    ram_re    = 1'b0;
    ram_raddr = AW'(idx);
    if (cmd.exec && kind == tcw_pkg::KIND_PUT && printable) begin
      ram_we    = 1'b1;
      ram_waddr = cur_addr;
      ram_wdata = {bg, fg, ch};
    end
    if (cmd.exec && kind == tcw_pkg::KIND_READ && in_range) begin
      ram_re = 1'b1;
    end
    if (cmd.scroll_step) begin
      ram_re    = copy_active;
      ram_raddr = cnt + AW'(COLUMNS);
      ram_we    = pend;
      ram_waddr = pend_addr;
      ram_wdata = ram_rdata;
    end
    if (cmd.fill_step) begin
      ram_we = 1'b1;
    end
  end

  tcw_ram #(
    .WIDTH ($bits(tcw_pkg::cell_t)),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= tcw_pkg::FG_RESET;
      bg <= tcw_pkg::BG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tcw_pkg::REG_FG: fg <= cfg_data;
        tcw_pkg::REG_BG: bg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (cmd.exec) begin
      case (kind)
        tcw_pkg::KIND_PUT: begin
          row <= row_next;
          col <= col_next;
        end
        tcw_pkg::KIND_CLEAR: begin
          row <= '0;
          col <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind <= req_kind;
      ch   <= req_char_code;
      idx  <= req_cell_index;
    end
    if (cmd.exec) begin
      rd <= '0;
    end else if (cmd.capture_read) begin
      rd <= ram_rdata;
    end
    pend_addr <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else begin
      pend <= cmd.scroll_step && copy_active;
      if (cmd.cnt_zero) begin
        cnt <= '0;
      end else if ((cmd.scroll_step && copy_active) ||
                   (cmd.fill_step && cnt != AW'(CELLS - 1))) begin
        cnt <= cnt + AW'(1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_result) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      rsp_cursor_pos <= tcw_pkg::pos_t'(cur_addr);
      rsp_cursor_row <= tcw_pkg::row_out_t'(row);
      rsp_cursor_col <= tcw_pkg::col_out_t'(col);
      rsp_read_data  <= rd;
    end
  end

  assign sts.kind        = kind;
  assign sts.bottom_wrap = bottom_wrap;
  assign sts.in_range    = in_range;
  assign sts.copy_done   = !copy_active;
  assign sts.fill_done   = cnt == AW'(CELLS - 1);
  assign sts.out_hold    = rsp_valid && !rsp_ready;

endmodule

FILE: rtl/tcw_controller.sv
// ----------------------------------------------------------------------------
// tcw_controller: sequencing state machine of the text console writer
// Steps through reset fill, execution, read wait, scroll, clear and result hand-off.
// ----------------------------------------------------------------------------
module tcw_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  tcw_pkg::ctl_sts_t  sts,
  output tcw_pkg::ctl_cmd_t  cmd
);

  tcw_pkg::state_t state;
  tcw_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcw_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tcw_pkg::ST_INIT: begin
        if (sts.fill_done) state_next = tcw_pkg::ST_IDLE;
      end
      tcw_pkg::ST_IDLE: begin
        if (req_valid) state_next = tcw_pkg::ST_EXEC;
      end
      tcw_pkg::ST_EXEC: begin
        case (sts.kind)
          tcw_pkg::KIND_PUT: begin
            state_next = sts.bottom_wrap ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_DONE;
          end
          tcw_pkg::KIND_CLEAR: begin
            state_next = tcw_pkg::ST_FILL;
          end
          tcw_pkg::KIND_READ: begin
            state_next = sts.in_range ? tcw_pkg::ST_RWAIT : tcw_pkg::ST_DONE;
          end
          default: begin
            state_next = tcw_pkg::ST_DONE;
          end
        endcase
      end
      tcw_pkg::ST_RWAIT: begin
        state_next = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_SCROLL: begin
        if (sts.copy_done) state_next = tcw_pkg::ST_FILL;
      end
      tcw_pkg::ST_FILL: begin
        if (sts.fill_done) state_next = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_DONE: begin
        if (!sts.out_hold) state_next = tcw_pkg::ST_IDLE;
      end
      default: begin
        state_next = tcw_pkg::ST_INIT;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      tcw_pkg::ST_INIT: begin
        cmd.fill_step  = 1'b1;
        cmd.fill_reset = 1'b1;
      end
      tcw_pkg::ST_IDLE: begin
        req_ready     = 1'b1;
        cmd.load_item = req_valid;
      end
      tcw_pkg::ST_EXEC: begin
        cmd.exec     = 1'b1;
        cmd.cnt_zero = (sts.kind == tcw_pkg::KIND_CLEAR) ||
                       (sts.kind == tcw_pkg::KIND_PUT && sts.bottom_wrap);
      end
      tcw_pkg::ST_RWAIT: begin
        cmd.capture_read = 1'b1;
      end
      tcw_pkg::ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
      end
      tcw_pkg::ST_FILL: begin
        cmd.fill_step = 1'b1;
      end
      tcw_pkg::ST_DONE: begin
        cmd.load_result = !sts.out_hold;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console with cursor
// Writes characters into a screen store, handles control characters, line
// wrap and scroll, clears the screen and reads back single cells.
// ----------------------------------------------------------------------------
//
//   Channel   Role    Payload                                        Accepted at
//   req       sink    kind, char_code, cell_index                    valid & ready
//   rsp       source  cursor_pos, cursor_row, cursor_col, read_data  valid & ready
//   cfg       sink    index, data                                    valid & ready
//
// An ordinary character, a control character, an out-of-range read or the
// unused kind passes through accept, execute and result load per transaction.
// An in-range read adds a wait state for the registered RAM read. A scroll
// copies one cell per cycle through the separate read and write ports and
// then blanks the bottom row; a clear writes one cell per cycle to all cells.
// After reset the store is filled with blank cells, and req.ready stays low
// during that pass while cfg writes are taken as ever. A result waits in its
// output register while rsp is stalled. The next transaction on req is still
// accepted and executed, but its result is loaded only once the waiting one
// has moved on.
//
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  tcw_req_if.sink     req,
  tcw_rsp_if.source   rsp,
  tcw_cfg_if.sink     cfg
);

  // Command and status groups between the sequencer and the datapath.
  tcw_pkg::ctl_cmd_t cmd;
  tcw_pkg::ctl_sts_t sts;

  // Configuration writes land directly in the colour registers, so the
  // channel never stalls.
  assign cfg.ready = 1'b1;

  // The controller owns the request handshake and decides, from the latched
  // transaction and the datapath status, which sweep or single access runs.
  tcw_controller u_ctl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the cursor, the colours, the screen RAM and the
  // result register that drives the response channel.
  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .req_kind       (req.kind),
    .req_char_code  (req.char_code),
    .req_cell_index (req.cell_index),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .rsp_ready      (rsp.ready),
    .rsp_valid      (rsp.valid),
    .rsp_cursor_pos (rsp.cursor_pos),
    .rsp_cursor_row (rsp.cursor_row),
    .rsp_cursor_col (rsp.cursor_col),
    .rsp_read_data  (rsp.read_data)
  );

endmodule

FILE: tb/sv/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker: cursor and screen scoreboard for the text console writer
// Follows every accepted request and register write with its own copy of the
// screen store and cursor, and compares each response with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic  clk,
  input  logic  rst,
  tcw_req_if    req,
  tcw_rsp_if    rsp,
  tcw_cfg_if    cfg,
  output int    mismatches,
  output int    outstanding
);

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    tcw_pkg::pos_t     pos;
    tcw_pkg::row_out_t row;
    tcw_pkg::col_out_t col;
    tcw_pkg::cell_t    data;
  } cursor_report_t;

  tcw_pkg::cell_t  screen [CELLS];
  int unsigned     cur_row;
  int unsigned     cur_col;
  tcw_pkg::color_t fg;
  tcw_pkg::color_t bg;
  cursor_report_t  pending_reports [$];

  function automatic tcw_pkg::cell_t blank_cell();
    return {bg, fg, tcw_pkg::CH_SPACE};
  endfunction

  function automatic void fill_screen(int first, int count);
    tcw_pkg::cell_t b;
    b = blank_cell();
    for (int i = first; i < first + count; i++) screen[i] = b;
  endfunction

  // Moves every row up by one and blanks the bottom row.
  function automatic void scroll_screen();
    for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
    fill_screen(CELLS - COLUMNS, COLUMNS);
    cur_row = ROWS - 1;
  endfunction

  function automatic void put_char(tcw_pkg::char_t c);
    case (c)
      tcw_pkg::CH_NL: begin
        cur_col = 0;
        cur_row++;
      end
      tcw_pkg::CH_CR:  cur_col = 0;
      tcw_pkg::CH_TAB: cur_col = (cur_col + tcw_pkg::TAB_STOP) & ~(tcw_pkg::TAB_STOP - 1);
      tcw_pkg::CH_BS: begin
        if (cur_col > 0) cur_col--;
      end
      default: begin
        screen[cur_row * COLUMNS + cur_col] = {bg, fg, c};
        cur_col++;
      end
    endcase
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= ROWS) scroll_screen();
  endfunction

  function automatic cursor_report_t console_step(tcw_pkg::kind_t k, tcw_pkg::char_t c,
                                                  tcw_pkg::idx_t idx);
    cursor_report_t r;
    tcw_pkg::cell_t d;
    d = '0;
    case (k)
      tcw_pkg::KIND_PUT:   put_char(c);
      tcw_pkg::KIND_CLEAR: begin
        fill_screen(0, CELLS);
        cur_row = 0;
        cur_col = 0;
      end
      tcw_pkg::KIND_READ: begin
        if (idx < CELLS) d = screen[idx];
      end
      default: ;
    endcase
    r.pos  = tcw_pkg::pos_t'(cur_row * COLUMNS + cur_col);
    r.row  = tcw_pkg::row_out_t'(cur_row);
    r.col  = tcw_pkg::col_out_t'(cur_col);
    r.data = d;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    cursor_report_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen[i] = tcw_pkg::RESET_CELL;
      cur_row = 0;
      cur_col = 0;
      fg = tcw_pkg::FG_RESET;
      bg = tcw_pkg::BG_RESET;
      pending_reports.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      // A colour write only changes what later writes, blanks and scrolls use.
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == tcw_pkg::REG_FG) fg = cfg.data;
        else if (cfg.index == tcw_pkg::REG_BG) bg = cfg.data;
      end
      if (req.valid && req.ready)
        pending_reports.push_back(console_step(req.kind, req.char_code, req.cell_index));
      if (rsp.valid && rsp.ready) begin
        if (pending_reports.size() == 0) begin
          mismatches++;
          $display("%0t: response with nothing expected, actual pos 0x%0h data 0x%0h",
                   $time, rsp.cursor_pos, rsp.read_data);
        end else begin
          want = pending_reports.pop_front();
          check_field("cursor_pos", want.pos, rsp.cursor_pos);
          check_field("cursor_row", want.row, rsp.cursor_row);
          check_field("cursor_col", want.col, rsp.cursor_col);
          check_field("read_data", want.data, rsp.read_data);
        end
      end
      outstanding <= pending_reports.size();
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the text console writer
// Drives requests with random gaps and colour writes in bursts, stalls the
// response side at random, and gives the verdict from the scoreboard's counts.
// ----------------------------------------------------------------------------
module testbench;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // The fourth request kind does nothing but report the cursor, and the
  // fourth register index selects no register. Neither has a package name.
  localparam tcw_pkg::kind_t    KIND_NOP  = 2'd3;
  localparam tcw_pkg::reg_idx_t REG_SPARE = 2'd3;

  localparam int RANDOM_ITEMS = 1350;
  localparam int PHASES       = 5;
  // A clear or a scroll walks the whole store with nothing accepted, and the
  // clearing pass after reset is as long. The limit is well above that walk.
  localparam int STALL_LIMIT  = 20000;

  logic clk = 1'b0;
  logic rst;

  tcw_req_if req_ch ();
  tcw_rsp_if rsp_ch ();
  tcw_cfg_if cfg_ch ();

  int mismatches;
  int outstanding;
  int quiet_cycles;
  int rsp_hold;
  int rsp_wait;
  // When set, neither side idles, so back-to-back transactions are covered.
  bit steady;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  text_console_writer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) console_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg         (cfg_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Response side: after each accepted transaction, ready may drop for a random
  // wait before it rises again; it never drops while steady is set.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_hold <= 0;
    end else if (rsp_hold > 1) begin
      rsp_hold <= rsp_hold - 1;
    end else if (rsp_hold == 1) begin
      rsp_hold <= 0;
      rsp_ch.ready <= 1'b1;
    end else if (rsp_ch.valid && rsp_ch.ready) begin
      rsp_wait = steady ? 0 : $urandom_range(0, 5);
      if (rsp_wait > 0) begin
        rsp_ch.ready <= 1'b0;
        rsp_hold <= rsp_wait;
      end
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Watchdog: any run that goes this long without a transaction on any
  // channel is hung.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one request. Valid stays high after the transaction so that a
  // following request with no gap goes out on the very next cycle; it is
  // lowered only when a gap is drawn or before a drain.
  task automatic send_item(tcw_pkg::kind_t k, tcw_pkg::char_t c, tcw_pkg::idx_t idx);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= k;
    req_ch.char_code  <= c;
    req_ch.cell_index <= idx;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Register writes come in a burst; the caller lowers valid after the last.
  task automatic write_reg(tcw_pkg::reg_idx_t idx, tcw_pkg::color_t value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Waits until every predicted response has come back. The scoreboard's
  // count is registered, so the task first waits on the clock before it looks.
  task automatic drain();
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Mostly printable text with enough newlines and tabs to reach the bottom
  // row and keep scrolling, mixed with reads, the odd clear and no-op kinds.
  // Fields that a kind ignores still carry random values.
  task automatic send_random_item();
    int             pick;
    tcw_pkg::char_t c;
    tcw_pkg::idx_t  idx;
    pick = $urandom_range(0, 99);
    c    = tcw_pkg::char_t'($urandom_range(0, 255));
    idx  = tcw_pkg::idx_t'($urandom_range(0, 2047));
    if (pick < 60) send_item(tcw_pkg::KIND_PUT, c, idx);
    else if (pick < 68) send_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_NL, idx);
    else if (pick < 71) send_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_CR, idx);
    else if (pick < 76) send_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_TAB, idx);
    else if (pick < 80) send_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_BS, idx);
    else if (pick < 92)
      send_item(tcw_pkg::KIND_READ, c, tcw_pkg::idx_t'($urandom_range(0, CELLS - 1)));
    else if (pick < 95) send_item(tcw_pkg::KIND_READ, c, idx);
    else if (pick < 97) send_item(tcw_pkg::KIND_CLEAR, c, idx);
    else send_item(KIND_NOP, c, idx);
  endtask

  initial begin
    tcw_pkg::color_t fg_next;
    tcw_pkg::color_t bg_next;

    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.kind       = tcw_pkg::KIND_PUT;
    req_ch.char_code  = '0;
    req_ch.cell_index = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = tcw_pkg::REG_FG;
    cfg_ch.data       = '0;
    steady            = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // The block blanks its store after reset and holds req.ready low meanwhile.
    do @(posedge clk); while (!req_ch.ready);

    // Directed part, under the reset colours. First the untouched store: the
    // first and last cells, the first index past the screen and the largest index.
    send_item(tcw_pkg::KIND_READ, 8'h00, 11'd0);
    send_item(tcw_pkg::KIND_READ, 8'hFF, tcw_pkg::idx_t'(CELLS - 1));
    send_item(tcw_pkg::KIND_READ, 8'h00, tcw_pkg::idx_t'(CELLS));
    send_item(tcw_pkg::KIND_READ, 8'h00, '1);
    send_item(KIND_NOP, 8'hFF, '1);
    // Extreme and odd character bytes, stored as they are.
    send_item(tcw_pkg::KIND_PUT, 8'h41, '0);
    send_item(tcw_pkg::KIND_PUT, 8'hFF, '0);
    send_item(tcw_pkg::KIND_PUT, 8'h00, '0);
    send_item(tcw_pkg::KIND_PUT, 8'h80, '1);
    // Backspace moves left without erasing, and does nothing at column 0.
    send_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_BS, '0);
    send_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_CR, '0);
    send_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_BS, '0);
    send_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_NL, '0);
    // Ten tabs walk a row in steps of eight; the last one runs past the
    // right edge and wraps to the next row.
    repeat (10) send_item(tcw_pkg::KIND_PUT, tcw_pkg::CH_TAB, '0);
    send_item(tcw_pkg::KIND_READ, 8'h00, 11'd0);
    send_item(tcw_pkg::KIND_READ, 8'h00, 11'd3);
    send_item(tcw_pkg::KIND_CLEAR, 8'h00, '0);
    send_item(tcw_pkg::KIND_READ, 8'h00, 11'd0);

    // Random phases. Each starts from an idle block, so the sender first waits
    // for every outstanding response, then new colours go in. Cells written
    // under older colours stay as they are and are read back later.
    for (int phase = 0; phase < PHASES; phase++) begin
      req_ch.valid <= 1'b0;
      drain();
      case (phase)
        0: begin
          fg_next = 4'd15;
          bg_next = 4'd0;
        end
        1: begin
          fg_next = 4'd0;
          bg_next = 4'd15;
        end
        2: begin
          fg_next = 4'd15;
          bg_next = 4'd15;
        end
        3: begin
          fg_next = 4'd0;
          bg_next = 4'd0;
        end
        default: begin
          fg_next = tcw_pkg::color_t'($urandom_range(0, 15));
          bg_next = tcw_pkg::color_t'($urandom_range(0, 15));
        end
      endcase
      write_reg(tcw_pkg::REG_FG, fg_next);
      write_reg(tcw_pkg::REG_BG, bg_next);
      // A write to the index with no register must change nothing.
      if (phase == 1) write_reg(REG_SPARE, tcw_pkg::color_t'($urandom_range(0, 15)));
      cfg_ch.valid <= 1'b0;
      steady = (phase == 2);
      repeat (RANDOM_ITEMS / PHASES) send_random_item();
    end
    steady = 1'b0;

    req_ch.valid <= 1'b0;
    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tcw_pkg.sv
rtl/tcw_if.sv
rtl/tcw_ram.sv
rtl/tcw_datapath.sv
rtl/tcw_controller.sv
rtl/text_console_writer.sv
tb/sv/tcw_checker.sv
tb/sv/testbench.sv
